// ===== src/polyphonic_voice_allocator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Concurrent assertion shorthands used by the voice allocator top level.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_VOICE_ALLOCATOR_TOP_ASSERT_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define PVA_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("voice allocator check failed");

// next-cycle implication
`define PVA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("voice allocator check failed");

`endif

// ===== src/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// Voice allocator package
// Event codes, result codes, voice entry layout and release time arithmetic.
// ----------------------------------------------------------------------------
package pva_pkg;

   localparam int VOICE_COUNT_DEFAULT = 16;
   localparam int RESULT_LIMIT        = 16;

   localparam logic [2:0] MODE_NOTE_ON      = 3'd0;
   localparam logic [2:0] MODE_NOTE_OFF     = 3'd1;
   localparam logic [2:0] MODE_PEDAL        = 3'd2;
   localparam logic [2:0] MODE_ALL_OFF      = 3'd3;
   localparam logic [2:0] MODE_FINISHED     = 3'd4;
   localparam logic [2:0] MODE_CTRL_RESET   = 3'd5;

   localparam logic ACT_TRIGGER = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   localparam logic [6:0]  PEDAL_THRESHOLD = 7'd64;
   localparam logic [13:0] SETTING_MAX     = 14'd10000;
   localparam logic [13:0] SETTING_RESET   = 14'd1500;
   localparam logic [9:0]  RELEASE_BASE_MS = 10'd20;
   // floor(6 * s / 100) as s * 503322 >> 23, exact for s up to 10000
   localparam logic [32:0] RELEASE_RECIP   = 33'd503322;
   localparam int          RELEASE_SHIFT   = 23;

   typedef struct packed {
      logic       active;
      logic [6:0] note;
      logic       pending;
   } voice_entry_type;

   function automatic logic [9:0] release_time(input logic [13:0] setting);
      logic [13:0] sat;
      logic [32:0] prod;
      sat  = (setting > SETTING_MAX) ? SETTING_MAX : setting;
      prod = 33'(sat) * RELEASE_RECIP;
      return prod[RELEASE_SHIFT+9:RELEASE_SHIFT] + RELEASE_BASE_MS;
   endfunction

endpackage

// ===== src/pva_ram.sv =====
// ----------------------------------------------------------------------------
// Voice allocator RAM
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pva_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data <= mem[read_address];
   end

endmodule

// ===== src/polyphonic_voice_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Polyphonic voice allocator
// Turns note, pedal and voice events into trigger and release commands.
//
//   channel   ports                          handshake
//   event     start, busy, req_*             transfer when start && !busy
//   command   rsp_valid, rsp_*               each valid for a single cycle, no stall
//   setting   csr_write_enable, csr_write_*  written when enable is high
//
// Note on, note off, releasing pedal-up and all-notes-off hold busy after
// the transfer until the scan and the done state are through: the voice RAM
// read port steps through one voice per cycle, and no new event is taken.
// Other events leave busy low. Commands leave one per cycle at most.
// Synchronous reset clears voice valid bits, pedal and steal pointer at once.
// ----------------------------------------------------------------------------
`include "polyphonic_voice_allocator_top_assert.svh"

module polyphonic_voice_allocator_top #(
   parameter int VOICE_COUNT = pva_pkg::VOICE_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [6:0]  req_note_number,
   input  logic [6:0]  req_strike_velocity,
   input  logic [6:0]  req_pedal_value,
   input  logic [3:0]  req_finished_voice,
   output logic        rsp_valid,
   output logic        rsp_action,
   output logic [3:0]  rsp_voice_index,
   output logic [6:0]  rsp_voice_note,
   output logic [6:0]  rsp_trigger_velocity,
   output logic [9:0]  rsp_release_ms,
   output logic        rsp_last_result,
   input  logic        csr_write_enable,
   input  logic [13:0] csr_write_data
);

   import pva_pkg::*;

   localparam int VIDX_W = $clog2(VOICE_COUNT);
   localparam int IDX_PAD = (VIDX_W > 4) ? VIDX_W : 4;
   localparam int ENTRY_W = $bits(voice_entry_type);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type         state_ff;
   logic [VIDX_W:0]   issue_ff;
   logic              proc_valid_ff;
   logic [VIDX_W-1:0] proc_index_ff;
   logic [VOICE_COUNT-1:0] valid_ff;

   logic [2:0]        mode_ff;
   logic [6:0]        note_ff;
   logic [6:0]        vel_ff;
   logic              pedal_down_ff;
   logic [VIDX_W-1:0] steal_ff;
   logic [9:0]        release_ms_ff;

   logic              match_found_ff;
   logic [VIDX_W-1:0] match_idx_ff;
   logic              idle_found_ff;
   logic [VIDX_W-1:0] idle_idx_ff;

   logic              hold_valid_ff;
   logic [VIDX_W-1:0] hold_index_ff;
   logic [6:0]        hold_note_ff;
   logic [4:0]        result_count_ff;

   logic              rsp_valid_ff;
   logic              rsp_action_ff;
   logic [3:0]        rsp_voice_index_ff;
   logic [6:0]        rsp_voice_note_ff;
   logic [6:0]        rsp_trigger_velocity_ff;
   logic [9:0]        rsp_release_ms_ff;
   logic              rsp_last_result_ff;

   logic              accept;
   logic              issuing;
   logic              pedal_on;
   logic              fin_in_range;
   logic [ENTRY_W-1:0] ram_rdata;
   voice_entry_type   ent;
   logic              ram_we;
   logic [VIDX_W-1:0] ram_waddr;
   voice_entry_type   ram_wdata;
   logic              rel_hit;
   logic [VIDX_W-1:0] chosen;
   logic [VIDX_W-1:0] steal_in;

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign issuing      = (issue_ff < (VIDX_W+1)'(VOICE_COUNT));
   assign pedal_on     = (req_pedal_value >= PEDAL_THRESHOLD);
   assign fin_in_range = (7'(req_finished_voice) < 7'(VOICE_COUNT));
   assign ent          = valid_ff[proc_index_ff] ? voice_entry_type'(ram_rdata) : '0;
   assign chosen       = match_found_ff ? match_idx_ff :
                         (idle_found_ff ? idle_idx_ff : steal_ff);
   assign steal_in     = (steal_ff == VIDX_W'(VOICE_COUNT - 1)) ? '0 : steal_ff + 1'b1;

   function automatic logic [3:0] low_index(input logic [VIDX_W-1:0] idx);
      logic [IDX_PAD-1:0] wide;
      wide = IDX_PAD'(idx);
      return wide[3:0];
   endfunction

   pva_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (VOICE_COUNT)
   ) u_voice_ram (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (issue_ff[VIDX_W-1:0]),
      .read_data     (ram_rdata)
   );

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = proc_index_ff;
      ram_wdata = ent;
      rel_hit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_FINISHED) && fin_in_range) begin
               ram_we    = 1'b1;
               ram_waddr = VIDX_W'(req_finished_voice);
               ram_wdata = '0;
            end
         end
         ST_SCAN: begin
            if (proc_valid_ff) begin
               case (mode_ff)
                  MODE_NOTE_OFF: begin
                     if (ent.active && (ent.note == note_ff)) begin
                        ram_we = 1'b1;
                        if (pedal_down_ff) begin
                           ram_wdata.pending = 1'b1;
                        end else begin
                           ram_wdata.pending = 1'b0;
                           rel_hit           = 1'b1;
                        end
                     end
                  end
                  MODE_PEDAL: begin
                     if (ent.active && ent.pending) begin
                        ram_we            = 1'b1;
                        ram_wdata.pending = 1'b0;
                        rel_hit           = 1'b1;
                     end
                  end
                  MODE_ALL_OFF: begin
                     if (ent.active) begin
                        ram_we            = 1'b1;
                        ram_wdata.pending = 1'b0;
                        rel_hit           = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (mode_ff == MODE_NOTE_ON) begin
               ram_we            = 1'b1;
               ram_waddr         = chosen;
               ram_wdata.active  = 1'b1;
               ram_wdata.note    = note_ff;
               ram_wdata.pending = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         issue_ff        <= '0;
         proc_valid_ff   <= 1'b0;
         valid_ff        <= '0;
         pedal_down_ff   <= 1'b0;
         steal_ff        <= '0;
         release_ms_ff   <= release_time(SETTING_RESET);
         hold_valid_ff   <= 1'b0;
         result_count_ff <= '0;
         match_found_ff  <= 1'b0;
         idle_found_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_write_enable) begin
            release_ms_ff <= release_time(csr_write_data);
         end
         if (ram_we) begin
            valid_ff[ram_waddr] <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  mode_ff         <= req_mode;
                  note_ff         <= req_note_number;
                  vel_ff          <= req_strike_velocity;
                  issue_ff        <= '0;
                  proc_valid_ff   <= 1'b0;
                  match_found_ff  <= 1'b0;
                  idle_found_ff   <= 1'b0;
                  hold_valid_ff   <= 1'b0;
                  result_count_ff <= '0;
                  case (req_mode)
                     MODE_NOTE_ON, MODE_NOTE_OFF: begin
                        state_ff <= ST_SCAN;
                     end
                     MODE_ALL_OFF: begin
                        state_ff      <= ST_SCAN;
                        pedal_down_ff <= 1'b0;
                     end
                     MODE_PEDAL: begin
                        pedal_down_ff <= pedal_on;
                        if (pedal_down_ff && !pedal_on) begin
                           state_ff <= ST_SCAN;
                        end
                     end
                     MODE_CTRL_RESET: begin
                        pedal_down_ff <= 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               proc_valid_ff <= issuing;
               proc_index_ff <= issue_ff[VIDX_W-1:0];
               if (issuing) begin
                  issue_ff <= issue_ff + 1'b1;
               end else if (!proc_valid_ff) begin
                  state_ff <= ST_DONE;
               end
               if (proc_valid_ff && (mode_ff == MODE_NOTE_ON)) begin
                  if (ent.active && (ent.note == note_ff) && !match_found_ff) begin
                     match_found_ff <= 1'b1;
                     match_idx_ff   <= proc_index_ff;
                  end
                  if (!ent.active && !idle_found_ff) begin
                     idle_found_ff <= 1'b1;
                     idle_idx_ff   <= proc_index_ff;
                  end
               end
               if (rel_hit && (result_count_ff < 5'(RESULT_LIMIT))) begin
                  if (hold_valid_ff) begin
                     rsp_valid_ff            <= 1'b1;
                     rsp_action_ff           <= ACT_RELEASE;
                     rsp_voice_index_ff      <= low_index(hold_index_ff);
                     rsp_voice_note_ff       <= hold_note_ff;
                     rsp_trigger_velocity_ff <= '0;
                     rsp_release_ms_ff       <= release_ms_ff;
                     rsp_last_result_ff      <= 1'b0;
                  end
                  hold_valid_ff   <= 1'b1;
                  hold_index_ff   <= proc_index_ff;
                  hold_note_ff    <= ent.note;
                  result_count_ff <= result_count_ff + 1'b1;
               end
            end
            ST_DONE: begin
               state_ff <= ST_IDLE;
               if (mode_ff == MODE_NOTE_ON) begin
                  if (!match_found_ff && !idle_found_ff) begin
                     steal_ff <= steal_in;
                  end
                  rsp_valid_ff            <= 1'b1;
                  rsp_action_ff           <= ACT_TRIGGER;
                  rsp_voice_index_ff      <= low_index(chosen);
                  rsp_voice_note_ff       <= note_ff;
                  rsp_trigger_velocity_ff <= vel_ff;
                  rsp_release_ms_ff       <= '0;
                  rsp_last_result_ff      <= 1'b1;
               end else if (hold_valid_ff) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_action_ff           <= ACT_RELEASE;
                  rsp_voice_index_ff      <= low_index(hold_index_ff);
                  rsp_voice_note_ff       <= hold_note_ff;
                  rsp_trigger_velocity_ff <= '0;
                  rsp_release_ms_ff       <= release_ms_ff;
                  rsp_last_result_ff      <= 1'b1;
               end
               hold_valid_ff <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_action           = rsp_action_ff;
   assign rsp_voice_index      = rsp_voice_index_ff;
   assign rsp_voice_note       = rsp_voice_note_ff;
   assign rsp_trigger_velocity = rsp_trigger_velocity_ff;
   assign rsp_release_ms       = rsp_release_ms_ff;
   assign rsp_last_result      = rsp_last_result_ff;

   `PVA_ASSERT_HOLDS(a_trigger_is_last, clock, reset,
      rsp_valid_ff && (rsp_action_ff == ACT_TRIGGER), rsp_last_result_ff)
   `PVA_ASSERT_HOLDS(a_idle_holds_nothing, clock, reset,
      state_ff == ST_IDLE, !hold_valid_ff)
   `PVA_ASSERT_NEXT(a_note_on_goes_busy, clock, reset,
      accept && (req_mode == MODE_NOTE_ON), busy)
   `PVA_ASSERT_HOLDS(a_result_limit, clock, reset,
      1'b1, result_count_ff <= 5'(RESULT_LIMIT))

endmodule
